// File: hdl/bldc_pkg.sv
// bldc_pkg: shared constants and controller/datapath interface types
// for the bitmap line draw and count block; no dependencies
package bldc_pkg;

   // storage defaults, handed to the top level parameters
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_LENGTH = 256;

   // field widths
   localparam int FIELD_W   = 10;
   localparam int CFG_W     = 9;
   localparam int COUNT_W   = 11;
   localparam int CSR_IDX_W = 1;
   // walk coordinates: covers clamped minor steps and bounds up to 1024
   localparam int COORD_W   = 12;

   // register reset values
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd182;
   localparam logic [CFG_W-1:0] LENGTH_RESET = 9'd243;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_IDX  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_IDX = 1'b1;

   // operation codes
   localparam logic OP_DRAW  = 1'b0;
   localparam logic OP_COUNT = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic clear_row;  // zero one bitmap row
      logic load;       // capture the request word
      logic orient;     // swap axes of steep lines
      logic order;      // order end points along the major axis
      logic delta;      // deltas, error term and minor direction
      logic step;       // visit one point
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last; // last row of the clearing pass
      logic more;       // major coordinate still within the line
   } status_type;

endpackage

// File: hdl/bitmap_line_draw_and_count_top.sv
// bitmap_line_draw_and_count_top: line draw and count over a one-bit bitmap
// depends on bldc_pkg, bldc_ctrl, bldc_datapath
//
//   channel   ports                               handshake
//   request   start, busy, req_*                  start && !busy
//   result    rsp_valid, rsp_match_count          one-cycle strobe
//   config    csr_valid, csr_ready, csr_index/data csr_valid && csr_ready
//
// busy stays high through the orient, order and delta setup states and the walk
// state; points walked = max(end major - max(start major, 0), 0) + 1, 1 to 512;
// one point per cycle
// the result strobe comes in the first cycle with busy low, where the next
// word may already be taken; results cannot be held off
// after reset a clearing pass zeroes one bitmap row per cycle, with busy high;
// configuration writes are taken at any time
module bitmap_line_draw_and_count_top #(
   parameter int MAX_WIDTH  = bldc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_LENGTH = bldc_pkg::DEF_MAX_LENGTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic signed [bldc_pkg::FIELD_W-1:0]   req_start_x,
   input  logic signed [bldc_pkg::FIELD_W-1:0]   req_start_y,
   input  logic signed [bldc_pkg::FIELD_W-1:0]   req_end_x,
   input  logic signed [bldc_pkg::FIELD_W-1:0]   req_end_y,
   input  logic                                  req_bit_value,
   output logic                                  rsp_valid,
   output logic [bldc_pkg::COUNT_W-1:0]          rsp_match_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bldc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bldc_pkg::CFG_W-1:0]            csr_data
);

   bldc_pkg::cmd_type    cmd;
   bldc_pkg::status_type status;

   logic [bldc_pkg::CFG_W-1:0] width_ff, width_in;
   logic [bldc_pkg::CFG_W-1:0] length_ff, length_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      length_in = length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bldc_pkg::CSR_WIDTH_IDX:  width_in  = csr_data;
            bldc_pkg::CSR_LENGTH_IDX: length_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bldc_pkg::WIDTH_RESET;
         length_ff <= bldc_pkg::LENGTH_RESET;
      end else begin
         width_ff  <= width_in;
         length_ff <= length_in;
      end
   end

   // sequencer
   bldc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // bitmap and walk datapath
   bldc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .width_in_use  (width_ff),
      .length_in_use (length_ff),
      .operation     (req_operation),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .bit_value     (req_bit_value),
      .match_count   (rsp_match_count)
   );

endmodule

// File: hdl/bldc_ctrl.sv
// bldc_ctrl: sequencing state machine for clearing, setup and walking
// depends on bldc_pkg
module bldc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bldc_pkg::status_type status,
   output bldc_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ORIENT,
      ST_ORDER,
      ST_DELTA,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // command decode
   always_comb begin
      cmd           = '0;
      cmd.clear_row = (state_ff == ST_CLEAR);
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.orient    = (state_ff == ST_ORIENT);
      cmd.order     = (state_ff == ST_ORDER);
      cmd.delta     = (state_ff == ST_DELTA);
      cmd.step      = (state_ff == ST_WALK) && status.more;
   end

   // next state and registered outputs
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ORIENT;
               busy_in  = 1'b1;
            end
         end
         ST_ORIENT: state_in = ST_ORDER;
         ST_ORDER:  state_in = ST_DELTA;
         ST_DELTA:  state_in = ST_WALK;
         ST_WALK: begin
            // last compare lands at this edge, so the count is final next cycle
            if (!status.more) begin
               state_in     = ST_IDLE;
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/bldc_datapath.sv
// bldc_datapath: bitmap memory, line setup and stepping registers, counter
// depends on bldc_pkg
module bldc_datapath #(
   parameter int MAX_WIDTH  = bldc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_LENGTH = bldc_pkg::DEF_MAX_LENGTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bldc_pkg::cmd_type                  cmd,
   output bldc_pkg::status_type               status,
   input  logic [bldc_pkg::CFG_W-1:0]         width_in_use,
   input  logic [bldc_pkg::CFG_W-1:0]         length_in_use,
   input  logic                               operation,
   input  logic signed [bldc_pkg::FIELD_W-1:0] start_x,
   input  logic signed [bldc_pkg::FIELD_W-1:0] start_y,
   input  logic signed [bldc_pkg::FIELD_W-1:0] end_x,
   input  logic signed [bldc_pkg::FIELD_W-1:0] end_y,
   input  logic                               bit_value,
   output logic [bldc_pkg::COUNT_W-1:0]       match_count
);

   localparam int CW    = bldc_pkg::COORD_W;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_LENGTH);

   // bitmap: one row per address, bit writes inside a row
   logic [MAX_WIDTH-1:0] bitmap_mem [MAX_LENGTH];

   logic [ROW_W-1:0] clr_row_ff, clr_row_in;

   // command word
   logic counting_ff, bit_ff;
   logic [CW-1:0] xb_ff, xb_in, yb_ff, yb_in;

   // walk state in the swapped frame
   logic signed [CW-1:0] a_ff, a_in, b_ff, b_in, a1_ff, a1_in, b1_ff, b1_in;
   logic signed [CW-1:0] err_ff, err_in;
   logic [CW-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                 steep_ff, steep_in, up_ff, up_in;

   // count pipeline
   logic                 pend_ff, rd_bit_ff;
   logic [bldc_pkg::COUNT_W-1:0] count_ff, count_in;

   // setup helpers
   logic signed [CW-1:0] dxr, dyr, db;
   logic [CW-1:0]        adx, ady;
   logic                 steep;

   // step helpers
   logic [CW-1:0]        a_c, b_c, px, py;
   logic signed [CW-1:0] err_t;
   logic                 inb, rd_en, wr_en;
   logic [COL_W-1:0]     col;
   logic [ROW_W-1:0]     row;

   // clearing pass row counter
   assign clr_row_in        = cmd.clear_row ? clr_row_ff + 1'b1 : clr_row_ff;
   assign status.clear_last = (clr_row_ff == ROW_W'(MAX_LENGTH - 1));

   // steepness from the raw end points
   always_comb begin
      dxr   = a1_ff - a_ff;
      dyr   = b1_ff - b_ff;
      adx   = dxr[CW-1] ? CW'(-dxr) : CW'(dxr);
      ady   = dyr[CW-1] ? CW'(-dyr) : CW'(dyr);
      steep = ady > adx;
      db    = b1_ff - b_ff;
   end

   // current point: negative coordinates clamp to zero
   always_comb begin
      a_c   = a_ff[CW-1] ? '0 : CW'(a_ff);
      b_c   = b_ff[CW-1] ? '0 : CW'(b_ff);
      px    = steep_ff ? b_c : a_c;
      py    = steep_ff ? a_c : b_c;
      inb   = (px < xb_ff) && (py < yb_ff);
      col   = px[COL_W-1:0];
      row   = py[ROW_W-1:0];
      err_t = err_ff - $signed(dy_ff);
      rd_en = cmd.step && inb && counting_ff;
      wr_en = cmd.step && inb && !counting_ff;
   end

   assign status.more = (a_ff <= a1_ff);

   // next values of the walk registers
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      a1_in    = a1_ff;
      b1_in    = b1_ff;
      err_in   = err_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      steep_in = steep_ff;
      up_in    = up_ff;
      xb_in    = xb_ff;
      yb_in    = yb_ff;
      count_in = count_ff;
      if (cmd.load) begin
         a_in     = CW'(start_x);
         b_in     = CW'(start_y);
         a1_in    = CW'(end_x);
         b1_in    = CW'(end_y);
         xb_in    = (CW'(width_in_use) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                         : CW'(width_in_use);
         yb_in    = (CW'(length_in_use) > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH)
                                                           : CW'(length_in_use);
         count_in = '0;
      end else if (cmd.orient) begin
         steep_in = steep;
         if (steep) begin
            a_in  = b_ff;
            b_in  = a_ff;
            a1_in = b1_ff;
            b1_in = a1_ff;
         end
      end else if (cmd.order) begin
         if (a_ff > a1_ff) begin
            a_in  = a1_ff;
            a1_in = a_ff;
            b_in  = b1_ff;
            b1_in = b_ff;
         end
      end else if (cmd.delta) begin
         dx_in  = CW'(dxr);
         dy_in  = db[CW-1] ? CW'(-db) : CW'(db);
         err_in = dxr >>> 1;
         up_in  = b_ff < b1_ff;
      end else if (cmd.step) begin
         a_in = $signed(a_c + 1'b1);
         if (err_t[CW-1]) begin
            b_in   = up_ff ? $signed(b_c + 1'b1) : $signed(b_c - 1'b1);
            err_in = err_t + $signed(dx_ff);
         end else begin
            b_in   = $signed(b_c);
            err_in = err_t;
         end
      end
      // compare of the bit read in the previous cycle
      if (pend_ff && (rd_bit_ff == bit_ff)) begin
         count_in = count_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
         pend_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         clr_row_ff <= clr_row_in;
         pend_ff    <= rd_en;
         count_ff   <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         counting_ff <= (operation == bldc_pkg::OP_COUNT);
         bit_ff      <= bit_value;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      err_ff   <= err_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      steep_ff <= steep_in;
      up_ff    <= up_in;
      xb_ff    <= xb_in;
      yb_ff    <= yb_in;
   end

   // bitmap memory: row clear or single bit write, registered bit read
   always_ff @(posedge clock) begin
      if (cmd.clear_row) begin
         bitmap_mem[clr_row_ff] <= '0;
      end else if (wr_en) begin
         bitmap_mem[row][col] <= bit_ff;
      end
      if (rd_en) begin
         rd_bit_ff <= bitmap_mem[row][col];
      end
   end

   assign match_count = count_ff;

endmodule

// File: hdl/bldc_checker.sv
// bldc_checker: port-level checks for the bitmap line draw and count block
// depends on bldc_pkg; bound to bitmap_line_draw_and_count_top
module bldc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_operation,
   input  logic                           rsp_valid,
   input  logic [bldc_pkg::COUNT_W-1:0]   rsp_match_count
);

   logic op_ff;

   // operation of the word in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= bldc_pkg::OP_DRAW;
      end else if (start && !busy) begin
         op_ff <= req_operation;
      end
   end

   // an accepted word makes the block busy at once
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // a result is shown only once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // single result per word
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // draw commands report a zero count
   a_draw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (op_ff == bldc_pkg::OP_DRAW) |-> rsp_match_count == '0)
      else $error("draw command gave a nonzero count");

   // count never exceeds 1024
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_count <= bldc_pkg::COUNT_W'(1024))
      else $error("count out of range");

endmodule

bind bitmap_line_draw_and_count_top bldc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_match_count (rsp_match_count)
);
